// File: rtl/cut_pkg.sv
package cut_pkg;

    localparam logic [7:0] LEAD_D0 = 8'hD0;
    localparam logic [7:0] LEAD_D1 = 8'hD1;
    localparam logic [7:0] TERM    = 8'h00;

    // letter positions of the uppercase hard and soft signs (emit nothing)
    localparam logic [5:0] IDX_HARD = 6'd27;
    localparam logic [5:0] IDX_SOFT = 6'd29;
    localparam logic [5:0] IDX_JO   = 6'd6;

    // text[0] is sent first
    typedef struct packed {
        logic [0:3][7:0] text;
        logic [2:0]      len;
    } spell_t;

    typedef struct packed {
        logic [0:3][7:0] text;
        logic [2:0]      len;   // 1..4 beats
        logic            eot;   // last beat is the terminator
    } run_t;

    function automatic spell_t letter_spell(input logic [5:0] idx);
        spell_t r;
        r = '{text: 32'h0, len: 3'd1};
        case (idx)
            6'd0:  r = '{text: {"a", 24'h0},    len: 3'd1};
            6'd1:  r = '{text: {"b", 24'h0},    len: 3'd1};
            6'd2:  r = '{text: {"v", 24'h0},    len: 3'd1};
            6'd3:  r = '{text: {"g", 24'h0},    len: 3'd1};
            6'd4:  r = '{text: {"d", 24'h0},    len: 3'd1};
            6'd5:  r = '{text: {"e", 24'h0},    len: 3'd1};
            6'd6:  r = '{text: {"jo", 16'h0},   len: 3'd2};
            6'd7:  r = '{text: {"zh", 16'h0},   len: 3'd2};
            6'd8:  r = '{text: {"z", 24'h0},    len: 3'd1};
            6'd9:  r = '{text: {"i", 24'h0},    len: 3'd1};
            6'd10: r = '{text: {"j", 24'h0},    len: 3'd1};
            6'd11: r = '{text: {"k", 24'h0},    len: 3'd1};
            6'd12: r = '{text: {"l", 24'h0},    len: 3'd1};
            6'd13: r = '{text: {"m", 24'h0},    len: 3'd1};
            6'd14: r = '{text: {"n", 24'h0},    len: 3'd1};
            6'd15: r = '{text: {"o", 24'h0},    len: 3'd1};
            6'd16: r = '{text: {"p", 24'h0},    len: 3'd1};
            6'd17: r = '{text: {"r", 24'h0},    len: 3'd1};
            6'd18: r = '{text: {"s", 24'h0},    len: 3'd1};
            6'd19: r = '{text: {"t", 24'h0},    len: 3'd1};
            6'd20: r = '{text: {"u", 24'h0},    len: 3'd1};
            6'd21: r = '{text: {"f", 24'h0},    len: 3'd1};
            6'd22: r = '{text: {"kh", 16'h0},   len: 3'd2};
            6'd23: r = '{text: {"ts", 16'h0},   len: 3'd2};
            6'd24: r = '{text: {"ch", 16'h0},   len: 3'd2};
            6'd25: r = '{text: {"sh", 16'h0},   len: 3'd2};
            6'd26: r = '{text: "shch",          len: 3'd4};
            6'd27: r = '{text: {8'h22, 24'h0},  len: 3'd1};
            6'd28: r = '{text: {"y", 24'h0},    len: 3'd1};
            6'd29: r = '{text: {8'h27, 24'h0},  len: 3'd1};
            6'd30: r = '{text: {"eh", 16'h0},   len: 3'd2};
            6'd31: r = '{text: {"ju", 16'h0},   len: 3'd2};
            6'd32: r = '{text: {"ja", 16'h0},   len: 3'd2};
            default: r = '{text: 32'h0, len: 3'd1};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cyrillic_utf8_transliterator.sv
// Path: the run for an accepted byte is written into the run queue, and its beats are
// then loaded one by one into the back end's output register.
// Input: one byte a cycle while the run queue has room (QUEUE_DEPTH runs).
// Output: one beat a cycle from the back end while out_stall is low; a letter gives up to four beats,
// so a two-byte letter gives up to two output beats per input byte.
// Reset (rst_n low, async): held lead cleared, queue emptied, out_valid low.
module cyrillic_utf8_transliterator
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       end_of_text
);
    import cut_pkg::*;

    logic push, pop, q_full, q_not_empty;
    run_t wr_run, head;

    assign in_stall = q_full;

    cut_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .run      (wr_run)
    );

    cut_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_run    (wr_run),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    cut_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (q_not_empty),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text)
    );

endmodule

// File: rtl/cut_front.sv
module cut_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            q_full,
    output logic            push,
    output cut_pkg::run_t   run
);
    import cut_pkg::*;

    logic       pending_reg, pending_next;
    logic       page_reg, page_next;
    logic       accept;
    logic       has_run;
    logic [7:0] lead;
    logic       hit, upper;
    logic [4:0] p;
    logic [5:0] idx;
    spell_t     sp;

    assign accept = in_valid && !q_full;
    assign lead   = page_reg ? LEAD_D1 : LEAD_D0;

    // pair lookup: second byte against the held lead's page
    always_comb
    begin
        hit   = 1'b0;
        upper = 1'b0;
        p     = 5'd0;
        idx   = 6'd0;
        if (!page_reg)
        begin
            if (in_byte == 8'h81)
            begin
                hit   = 1'b1;
                upper = 1'b1;
                idx   = IDX_JO;
            end
            else if (in_byte inside {[8'h90:8'hAF]})
            begin
                hit   = 1'b1;
                upper = 1'b1;
                p     = 5'(in_byte - 8'h90);
            end
            else if (in_byte inside {[8'hB0:8'hBF]})
            begin
                hit = 1'b1;
                p   = 5'(in_byte - 8'hB0);
            end
        end
        else
        begin
            if (in_byte == 8'h91)
            begin
                hit = 1'b1;
                idx = IDX_JO;
            end
            else if (in_byte inside {[8'h80:8'h8F]})
            begin
                hit = 1'b1;
                p   = 5'(in_byte - 8'h70);
            end
        end
        // jo sits between e and zh
        if (hit && idx != IDX_JO)
            idx = (p < 5'd6) ? {1'b0, p} : 6'({1'b0, p} + 6'd1);
    end

    assign sp = letter_spell(idx);

    always_comb
    begin
        pending_next = pending_reg;
        page_next    = page_reg;
        has_run      = 1'b0;
        run          = '{text: 32'h0, len: 3'd1, eot: 1'b0};
        if (in_byte == TERM)
        begin
            has_run      = 1'b1;
            pending_next = 1'b0;
            page_next    = 1'b0;
            if (pending_reg)
                run = '{text: {lead, TERM, 16'h0}, len: 3'd2, eot: 1'b1};
            else
                run = '{text: {TERM, 24'h0}, len: 3'd1, eot: 1'b1};
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            page_next    = 1'b0;
            if (!hit)
            begin
                has_run = 1'b1;
                run     = '{text: {lead, in_byte, 16'h0}, len: 3'd2, eot: 1'b0};
            end
            else if (!(upper && (idx == IDX_HARD || idx == IDX_SOFT)))
            begin
                has_run  = 1'b1;
                run.text = sp.text;
                run.len  = sp.len;
                if (upper)
                    run.text[0] = sp.text[0] ^ 8'h20;
            end
        end
        else if (in_byte == LEAD_D0 || in_byte == LEAD_D1)
        begin
            pending_next = 1'b1;
            page_next    = (in_byte == LEAD_D1);
        end
        else
        begin
            has_run = 1'b1;
            run     = '{text: {in_byte, 24'h0}, len: 3'd1, eot: 1'b0};
        end
    end

    assign push = accept && has_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            page_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            page_reg    <= page_next;
        end
    end

endmodule

// File: rtl/cut_queue.sv
module cut_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cut_pkg::run_t   wr_run,
    input  logic            pop,
    output cut_pkg::run_t   head,
    output logic            not_empty,
    output logic            full
);
    import cut_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    run_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_run;
    end

endmodule

// File: rtl/cut_back.sv
module cut_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cut_pkg::run_t   head,
    input  logic            head_valid,
    output logic            pop,
    input  logic            out_stall,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            end_of_text
);
    import cut_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg, eot_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!valid_reg || !out_stall);
    assign is_last = ({1'b0, pos_reg} == 3'(head.len - 3'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = is_last ? 2'd0 : pos_reg + 2'd1;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.text[pos_reg];
            last_reg <= is_last;
            eot_reg  <= is_last && head.eot;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign end_of_text = eot_reg;

endmodule

// File: rtl/cut_checker.sv
module cut_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       end_of_text
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(end_of_text))
        else $error("stalled output beat changed");

    // a zero byte only ever appears as the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_byte == 8'h00) == end_of_text))
        else $error("zero byte and end_of_text disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> last_of_run)
        else $error("terminator not last of its run");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right out of reset");

endmodule

bind cyrillic_utf8_transliterator cut_checker u_chk (.*);
